>>> src/rcgi_pkg.sv
// ----------------------------------------------------------------------------
// rcgi_pkg
// Shared types, constants and the sRGB decode table builder for the RGB to
// CMYK converter with gray component replacement and ink limiting.
// ----------------------------------------------------------------------------
package rcgi_pkg;

  localparam int LIN_FRAC_BITS = 16;
  localparam int FIFO_DEPTH    = 4;

  // Configuration register indexes.
  localparam logic CFG_GCR   = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [10:0] GCR_RESET   = 11'd512;
  localparam logic [10:0] GCR_FULL    = 11'd1024;
  localparam logic [8:0]  LIMIT_RESET = 9'd300;

  // Wide enough for the largest supported fraction width plus one.
  typedef logic [24:0] rom_word_t;
  typedef rom_word_t rom_tab_t [256];

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // One entry of the gamma decode table, linear light in Q1.f.
  function automatic rom_word_t lin_entry(int unsigned v, int unsigned f);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] q;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] m2;
    logic [63:0] m4;
    logic [63:0] m5;
    logic [63:0] val;
    if (v <= 10) begin
      val = (((64'(v) * 64'd100) << f) + 64'd164730) / 64'd329460;
      return rom_word_t'(val);
    end
    n = 64'(v) * 64'd1000 + 64'd14025;
    u = ((n << 30) + 64'd134512) / 64'd269025;
    q = mul_q30(u, u);
    lo = 64'd0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      m2 = mul_q30(mid, mid);
      m4 = mul_q30(m2, m2);
      m5 = mul_q30(m4, mid);
      if (m5 <= q) lo = mid;
      else hi = mid - 64'd1;
    end
    val = mul_q30(q, lo);
    val = (val + (64'd1 << (29 - f))) >> (30 - f);
    return rom_word_t'(val);
  endfunction

  function automatic rom_tab_t build_rom(int unsigned f);
    rom_tab_t t;
    for (int unsigned v = 0; v < 256; v++) t[v] = lin_entry(v, f);
    return t;
  endfunction

endpackage

>>> src/rgb_to_cmyk_gcr_ink_limit.sv
// ----------------------------------------------------------------------------
// rgb_to_cmyk_gcr_ink_limit
// sRGB pixel to CMYK ink percentages with gray component replacement and a
// total ink limit.
//
//   Channel  Direction  Beat contents
//   in_      slave      tdata: red, green, blue (8 bits each)
//   out_     master     tdata: cyan, magenta, yellow, black (7 bits each)
//   cfg_     write      index 0 gcr_factor, index 1 ink_limit_percent
//
// One pixel is accepted every clock while in_tready is high; each result passes
// through the two bit-per-stage dividers (black removal and ink limit).
// rst_n is synchronous; it clears all valid flags and the queue and loads
// the register defaults.
// A stalled output holds the back end; the front end keeps filling the queue
// until it is full and then drops in_tready.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_gcr_ink_limit #(
  parameter int LINEAR_FRACTION_BITS = rcgi_pkg::LIN_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cyan [6:0], magenta [13:7], yellow [20:14],
                                  // black [27:21], zero [31:28]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int F = LINEAR_FRACTION_BITS;
  localparam int QW = 4 * (F + 1);

  logic [10:0]          gcr_r;
  logic [8:0]           limit_r;
  logic                 push;
  logic [QW-1:0]        push_data;
  logic                 pop;
  logic [QW-1:0]        pop_data;
  rcgi_pkg::fifo_stat_t stat;
  logic [27:0]          out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcr_r   <= rcgi_pkg::GCR_RESET;
      limit_r <= rcgi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rcgi_pkg::CFG_GCR:   gcr_r   <= cfg_wdata;
        rcgi_pkg::CFG_LIMIT: limit_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  rcgi_front #(.F(F)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .gcr(gcr_r), .stat, .push, .push_data
  );

  rcgi_fifo #(.W(QW), .DEPTH(rcgi_pkg::FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_data, .pop, .pop_data, .stat
  );

  rcgi_back #(.F(F)) u_back (
    .clk, .rst_n, .stat, .pop, .pop_data, .ink_limit(limit_r),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data
  );

  assign out_tdata = {4'd0, out_data};

endmodule

>>> src/rcgi_fifo.sv
// ----------------------------------------------------------------------------
// rcgi_fifo
// Short register queue between the decoding front end and the back end.
// ----------------------------------------------------------------------------
module rcgi_fifo #(
  parameter int W     = 68,
  parameter int DEPTH = rcgi_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         pop_data,
  output rcgi_pkg::fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + (AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == (AW+1)'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

>>> src/rcgi_front.sv
// ----------------------------------------------------------------------------
// rcgi_front
// Decodes each sRGB channel through the gamma table, inverts to raw ink and
// works out the black amount from the gray component.
// ----------------------------------------------------------------------------
module rcgi_front #(
  parameter int F = rcgi_pkg::LIN_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [23:0]          in_data,
  input  logic [10:0]          gcr,
  input  rcgi_pkg::fifo_stat_t stat,
  output logic                 push,
  output logic [4*(F+1)-1:0]   push_data
);

  localparam int W = F + 1;
  localparam logic [W-1:0] ONE_V = {1'b1, {F{1'b0}}};
  localparam rcgi_pkg::rom_tab_t LinRom = rcgi_pkg::build_rom(F);

  logic         s1_v_r;
  logic [W-1:0] lin_r [3];
  logic         s2_v_r;
  logic [W-1:0] raw_r [3];
  logic [W-1:0] k_r;

  logic [W-1:0]  raw_nxt [3];
  logic [W-1:0]  kb;
  logic [10:0]   g;
  logic [W+10:0] kprod;
  logic [W-1:0]  k_nxt;
  logic          adv1;
  logic          adv2;

  assign adv2     = !s2_v_r || !stat.full;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    for (int i = 0; i < 3; i++) raw_nxt[i] = ONE_V - lin_r[i];
    kb = raw_nxt[0];
    if (raw_nxt[1] < kb) kb = raw_nxt[1];
    if (raw_nxt[2] < kb) kb = raw_nxt[2];
    g     = (gcr > rcgi_pkg::GCR_FULL) ? rcgi_pkg::GCR_FULL : gcr;
    kprod = (W+11)'(kb) * (W+11)'(g) + (W+11)'(512);
    k_nxt = kprod[W+9:10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      lin_r[0] <= LinRom[in_data[7:0]][W-1:0];
      lin_r[1] <= LinRom[in_data[15:8]][W-1:0];
      lin_r[2] <= LinRom[in_data[23:16]][W-1:0];
    end
    if (adv2) begin
      raw_r <= raw_nxt;
      k_r   <= k_nxt;
    end
  end

  assign push      = s2_v_r && !stat.full;
  assign push_data = {k_r, raw_r[2], raw_r[1], raw_r[0]};

endmodule

>>> src/rcgi_divpipe.sv
// ----------------------------------------------------------------------------
// rcgi_divpipe
// Pipelined restoring divider, one quotient bit per stage, with several
// numerators sharing one divisor.
// ----------------------------------------------------------------------------
module rcgi_divpipe #(
  parameter int LANES = 3,
  parameter int NUM_W = 33,
  parameter int DEN_W = 17,
  parameter int Q_W   = 17,
  parameter int PAY_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]            in_den,
  input  logic [PAY_W-1:0]            in_pay,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quo,
  output logic [PAY_W-1:0]            out_pay
);

  // The quotient must fit in Q_W bits, so the remainder fits below den << Q_W.
  localparam int CW = DEN_W + Q_W;

  logic                        v_r   [Q_W+1];
  logic [LANES-1:0][CW-1:0]    rem_r [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quo_r [Q_W+1];
  logic [DEN_W-1:0]            den_r [Q_W];
  logic [PAY_W-1:0]            pay_r [Q_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) rem_r[0][l] <= CW'(in_num[l]);
      quo_r[0] <= '0;
      den_r[0] <= in_den;
      pay_r[0] <= in_pay;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_stage
    localparam int B = Q_W - s;
    logic [CW-1:0]             dsh;
    logic [LANES-1:0][CW-1:0]  rem_nxt;
    logic [LANES-1:0][Q_W-1:0] quo_nxt;

    always_comb begin
      dsh = CW'(den_r[s-1]) << B;
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[l] = rem_r[s-1][l];
        quo_nxt[l] = quo_r[s-1][l];
        if (rem_r[s-1][l] >= dsh) begin
          rem_nxt[l]    = rem_r[s-1][l] - dsh;
          quo_nxt[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_nxt;
        pay_r[s] <= pay_r[s-1];
      end
    end

    if (s < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt;
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[Q_W];
  assign out_quo   = quo_r[Q_W];
  assign out_pay   = pay_r[Q_W];

endmodule

>>> src/rcgi_back.sv
// ----------------------------------------------------------------------------
// rcgi_back
// Removes black from C, M and Y, applies the total ink limit and rounds each
// ink to whole percent into the output register.
// ----------------------------------------------------------------------------
module rcgi_back #(
  parameter int F = rcgi_pkg::LIN_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcgi_pkg::fifo_stat_t stat,
  output logic                 pop,
  input  logic [4*(F+1)-1:0]   pop_data,
  input  logic [8:0]           ink_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [27:0]          out_data
);

  localparam int W      = F + 1;
  localparam int NUM1_W = 2 * F + 1;
  localparam int DEN2_W = F + 9;
  localparam int NUM2_W = 2 * F + 10;
  localparam int TOT_W  = F + 3;
  localparam logic [W-1:0] ONE_V = {1'b1, {F{1'b0}}};

  logic be;

  // Black removal divider inputs.
  logic [W-1:0]                raw [3];
  logic [W-1:0]                k_in;
  logic                        full_black;
  logic [W-1:0]                den1;
  logic [2:0][NUM1_W-1:0]      num1;
  logic                        d1_v;
  logic [2:0][W-1:0]           q1;
  logic [W-1:0]                d1_k;

  // Limit test stage.
  logic                        l_v_r;
  logic [W-1:0]                l_ink_r [4];
  logic [DEN2_W-1:0]           l_tot100_r;
  logic                        l_apply_r;
  logic [TOT_W-1:0]            total_nxt;
  logic [DEN2_W-1:0]           tot100_nxt;

  // Product stage ahead of the limit divider.
  logic                        m_v_r;
  logic [W-1:0]                m_ink_r  [4];
  logic [W+8:0]                m_prod_r [4];
  logic [DEN2_W-1:0]           m_den_r;
  logic                        m_apply_r;
  logic [3:0][NUM2_W-1:0]      num2;

  logic                        d2_v;
  logic [3:0][W-1:0]           q2;

  logic                        out_v_r;
  logic [6:0]                  pct_r   [4];
  logic [6:0]                  pct_nxt [4];

  assign be  = !out_v_r || out_ready;
  assign pop = be && !stat.empty;

  always_comb begin
    for (int i = 0; i < 3; i++) raw[i] = pop_data[i*W +: W];
    k_in       = pop_data[3*W +: W];
    full_black = k_in[F];
    den1       = full_black ? W'(1) : ONE_V - k_in;
    for (int i = 0; i < 3; i++) begin
      num1[i] = full_black ? '0
              : (NUM1_W'(raw[i] - k_in) << F) + NUM1_W'(den1 >> 1);
    end
  end

  rcgi_divpipe #(
    .LANES(3), .NUM_W(NUM1_W), .DEN_W(W), .Q_W(W), .PAY_W(W)
  ) u_div_gcr (
    .clk, .rst_n, .en(be),
    .in_valid(!stat.empty), .in_num(num1), .in_den(den1), .in_pay(k_in),
    .out_valid(d1_v), .out_quo(q1), .out_pay(d1_k)
  );

  always_comb begin
    total_nxt  = TOT_W'(q1[0]) + TOT_W'(q1[1]) + TOT_W'(q1[2]) + TOT_W'(d1_k);
    tot100_nxt = DEN2_W'(total_nxt) * DEN2_W'(100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (be) begin
      l_v_r   <= d1_v;
      m_v_r   <= l_v_r;
      out_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      for (int i = 0; i < 3; i++) l_ink_r[i] <= q1[i];
      l_ink_r[3] <= d1_k;
      l_tot100_r <= tot100_nxt;
      l_apply_r  <= tot100_nxt > (DEN2_W'(ink_limit) << F);
      for (int i = 0; i < 4; i++) begin
        m_ink_r[i]  <= l_ink_r[i];
        m_prod_r[i] <= (W+9)'(l_ink_r[i]) * (W+9)'(ink_limit);
      end
      m_den_r   <= l_apply_r ? l_tot100_r : DEN2_W'(1);
      m_apply_r <= l_apply_r;
      pct_r     <= pct_nxt;
    end
  end

  // Without the limit the divisor is one, so the ink passes through unchanged.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num2[i] = m_apply_r ? (NUM2_W'(m_prod_r[i]) << F) + NUM2_W'(m_den_r >> 1)
                          : NUM2_W'(m_ink_r[i]);
    end
  end

  rcgi_divpipe #(
    .LANES(4), .NUM_W(NUM2_W), .DEN_W(DEN2_W), .Q_W(W), .PAY_W(1)
  ) u_div_limit (
    .clk, .rst_n, .en(be),
    .in_valid(m_v_r), .in_num(num2), .in_den(m_den_r), .in_pay(1'b0),
    .out_valid(d2_v), .out_quo(q2), .out_pay()
  );

  always_comb begin
    logic [F+7:0] p;
    logic [7:0]   pw;
    for (int i = 0; i < 4; i++) begin
      p  = (F+8)'(q2[i]) * (F+8)'(100) + ((F+8)'(1) << (F - 1));
      pw = p[F+7:F];
      pct_nxt[i] = (pw > 8'd100) ? 7'd100 : pw[6:0];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = {pct_r[3], pct_r[2], pct_r[1], pct_r[0]};

endmodule

>>> src/rcgi_checker.sv
// ----------------------------------------------------------------------------
// rcgi_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
module rcgi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // Every ink is a percentage, and the padding bits stay clear.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= 7'd100 && out_tdata[13:7] <= 7'd100 &&
                   out_tdata[20:14] <= 7'd100 && out_tdata[27:21] <= 7'd100 &&
                   out_tdata[31:28] == 4'd0)
    else $error("ink percentage out of range");

endmodule

bind rgb_to_cmyk_gcr_ink_limit rcgi_checker u_rcgi_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
